// File: design/asa_pkg.sv
`timescale 1ns / 1ps

package asa_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_ALLOCS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 1;
	localparam int ADDR_BITS_DEF    = 32;

	// Register reset values
	localparam logic [31:0] BASE_ADDRESS_RST = 32'd0;
	localparam logic [31:0] POOL_SIZE_RST    = 32'd65536;

	// Configuration register indexes
	localparam logic CFG_BASE_ADDRESS = 1'b0;
	localparam logic CFG_POOL_SIZE    = 1'b1;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_type_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOSPACE = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_FULL    = 3'd3,
		ST_BAD     = 3'd4
	} status_code_t;

	typedef enum logic {
		CTL_IDLE,
		CTL_EXEC
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture; // latch the request fields
		logic commit;  // update state, load the response register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rsp_stall; // response register full and not taken this cycle
	} dp_status_t;

endpackage

// File: design/asa_req_if.sv
`timescale 1ns / 1ps

interface asa_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] alloc_size;
	logic [7:0]  align_bytes;
	logic [31:0] release_addr;

	modport source (
		output valid, req_type, alloc_size, align_bytes, release_addr,
		input  ready
	);
	modport sink (
		input  valid, req_type, alloc_size, align_bytes, release_addr,
		output ready
	);
endinterface

// File: design/asa_rsp_if.sv
`timescale 1ns / 1ps

interface asa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] block_addr;
	logic [2:0]  status;
	logic [31:0] bytes_used;
	logic [6:0]  live_count;

	modport source (
		output valid, block_addr, status, bytes_used, live_count,
		input  ready
	);
	modport sink (
		input  valid, block_addr, status, bytes_used, live_count,
		output ready
	);
endinterface

// File: design/asa_cfg_if.sv
`timescale 1ns / 1ps

interface asa_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// File: design/asa_ram.sv
`timescale 1ns / 1ps

module asa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/asa_ctrl.sv
`timescale 1ns / 1ps

module asa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  asa_pkg::dp_status_t   dp_status,
	output asa_pkg::dp_cmd_t      dp_cmd
);

	asa_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asa_pkg::CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		req_ready      = 1'b0;
		dp_cmd.capture = 1'b0;
		dp_cmd.commit  = 1'b0;
		case (state_q)
			asa_pkg::CTL_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					dp_cmd.capture = 1'b1;
					state_d        = asa_pkg::CTL_EXEC;
				end
			end
			asa_pkg::CTL_EXEC: begin
				// wait for room in the response register
				if (!dp_status.rsp_stall) begin
					dp_cmd.commit = 1'b1;
					state_d       = asa_pkg::CTL_IDLE;
				end
			end
			default: begin
				state_d = asa_pkg::CTL_IDLE;
			end
		endcase
	end

endmodule

// File: design/asa_datapath.sv
`timescale 1ns / 1ps

module asa_datapath #(
	parameter int MAX_ALLOCS   = asa_pkg::MAX_ALLOCS_DEF,
	parameter int HEADER_BYTES = asa_pkg::HEADER_BYTES_DEF,
	parameter int ADDR_BITS    = asa_pkg::ADDR_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  asa_pkg::dp_cmd_t    dp_cmd,
	output asa_pkg::dp_status_t dp_status,
	input  logic                req_type,
	input  logic [31:0]         alloc_size,
	input  logic [7:0]          align_bytes,
	input  logic [31:0]         release_addr,
	asa_cfg_if.sink             cfg,
	asa_rsp_if.source           rsp
);

	localparam int AW = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
	localparam int DW = $clog2(MAX_ALLOCS + 1);
	localparam int FW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 1;

	// allocator state
	logic [ADDR_BITS-1:0] top_q;
	logic [31:0]          used_q;
	logic [DW-1:0]        depth_q;
	logic [31:0]          pool_q;

	// latched request
	logic        type_q;
	logic [31:0] size_q;
	logic [7:0]  align_q;
	logic [31:0] rel_q;

	// response register
	logic        rsp_valid_q;
	logic [31:0] block_addr_q;
	logic [2:0]  status_q;
	logic [31:0] bytes_used_q;
	logic [6:0]  live_count_q;

	logic [ADDR_BITS-1:0] top_d;
	logic [31:0]          used_d;
	logic [DW-1:0]        depth_d;
	logic [31:0]          addr_d;
	asa_pkg::status_code_t st_d;
	logic                 push;

	logic                 cfg_xfer;
	logic [7:0]           stk_rdata;

	// alignment adjustment
	logic       align_pow2;
	logic [7:0] align_mask;
	logic [7:0] adj_base;
	logic [7:0] hdr;
	logic [7:0] need;
	logic [7:0] adj_raise;
	logic [7:0] adj;

	// allocate path
	logic [33:0]          fit_sum;
	logic                 no_space;
	logic [ADDR_BITS-1:0] alloc_addr;
	logic [ADDR_BITS-1:0] alloc_top;

	// release path
	logic [ADDR_BITS-1:0] rel_a;
	logic [ADDR_BITS-1:0] span;
	logic [FW-1:0]        freed;
	logic [31:0]          used_free;
	logic [ADDR_BITS-1:0] free_top;

	assign cfg.ready = 1'b1;
	assign cfg_xfer  = cfg.valid & cfg.ready;

	assign align_pow2 = (align_q != 8'd0) && ((align_q & align_mask) == 8'd0);
	assign align_mask = align_q - 8'd1;
	assign adj_base   = (8'd0 - top_q[7:0]) & align_mask;
	assign hdr        = 8'(HEADER_BYTES);
	assign need       = hdr - adj_base;
	// round the shortfall up to a whole number of alignment steps
	assign adj_raise  = adj_base + ((need + align_mask) & ~align_mask);
	assign adj        = (adj_base < hdr) ? adj_raise : adj_base;

	assign fit_sum    = 34'(used_q) + 34'(adj) + 34'(size_q);
	assign no_space   = fit_sum > 34'(pool_q);
	assign alloc_addr = top_q + ADDR_BITS'(adj);
	assign alloc_top  = alloc_addr + ADDR_BITS'(size_q);

	assign rel_a     = ADDR_BITS'(rel_q);
	// distance back to the release address wraps at the address width
	assign span      = top_q - rel_a;
	assign freed     = FW'(span) + FW'(stk_rdata);
	assign used_free = (freed > FW'(used_q)) ? 32'd0 : 32'(FW'(used_q) - freed);
	assign free_top  = rel_a - ADDR_BITS'(stk_rdata);

	always_comb begin
		top_d   = top_q;
		used_d  = used_q;
		depth_d = depth_q;
		addr_d  = 32'd0;
		st_d    = asa_pkg::ST_OK;
		push    = 1'b0;
		if (type_q == asa_pkg::REQ_ALLOC) begin
			if (size_q == 32'd0 || !align_pow2) begin
				st_d = asa_pkg::ST_BAD;
			end else if (depth_q >= DW'(MAX_ALLOCS)) begin
				st_d = asa_pkg::ST_FULL;
			end else if (no_space) begin
				st_d = asa_pkg::ST_NOSPACE;
			end else begin
				addr_d  = 32'(alloc_addr);
				top_d   = alloc_top;
				used_d  = 32'(fit_sum);
				depth_d = depth_q + DW'(1);
				push    = 1'b1;
			end
		end else begin
			if (depth_q == DW'(0)) begin
				st_d = asa_pkg::ST_EMPTY;
			end else begin
				top_d   = free_top;
				used_d  = used_free;
				depth_d = depth_q - DW'(1);
			end
		end
	end

	// adjustment stack; read port always points at the top entry
	asa_ram #(
		.WIDTH(8),
		.DEPTH(MAX_ALLOCS)
	) u_stack (
		.clk  (clk),
		.we   (dp_cmd.commit & push),
		.waddr(AW'(depth_q)),
		.wdata(adj),
		.raddr(AW'(depth_q - DW'(1))),
		.rdata(stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= ADDR_BITS'(asa_pkg::BASE_ADDRESS_RST);
			used_q      <= 32'd0;
			depth_q     <= '0;
			pool_q      <= asa_pkg::POOL_SIZE_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_xfer) begin
				case (cfg.index)
					asa_pkg::CFG_BASE_ADDRESS: begin
						top_q   <= ADDR_BITS'(cfg.data);
						used_q  <= 32'd0;
						depth_q <= '0;
					end
					asa_pkg::CFG_POOL_SIZE: begin
						pool_q <= cfg.data;
					end
					default: begin
					end
				endcase
			end else if (dp_cmd.commit) begin
				top_q   <= top_d;
				used_q  <= used_d;
				depth_q <= depth_d;
			end
			if (dp_cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			type_q  <= req_type;
			size_q  <= alloc_size;
			align_q <= align_bytes;
			rel_q   <= release_addr;
		end
		if (dp_cmd.commit) begin
			block_addr_q <= addr_d;
			status_q     <= st_d;
			bytes_used_q <= used_d;
			live_count_q <= 7'(depth_d);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.block_addr = block_addr_q;
	assign rsp.status     = status_q;
	assign rsp.bytes_used = bytes_used_q;
	assign rsp.live_count = live_count_q;

	assign dp_status.rsp_stall = rsp_valid_q & ~rsp.ready;

endmodule

// File: design/aligned_stack_allocator.sv
`timescale 1ns / 1ps

// LIFO bump allocator with per-allocation alignment adjustment.
// Channels (valid/ready, transfer when both are high at a rising edge):
//   cfg : register writes, index 0 base_address (restarts the pool with
//         nothing in use), index 1 pool_size. Always ready; write only
//         while no request is in flight.
//   req : allocate (size, alignment) or release (address of latest block).
//   rsp : one result per request: address, status, bytes in use, live count.
// Timing: a request is taken in idle and executed in execute, which waits
// while the response register is stalled, so a new request is taken only
// after the last has executed; the response is registered, loaded on execute.
// The idle state covers the registered read of the adjustment stack memory.
// Receiver stall: the response register holds its result; one more
// request is taken and waits in execute until the register frees up.
// Reset: top = 0, pool_size = 65536, nothing in use, stack empty. The
// stack memory needs no clearing pass, since only written entries are read.
module aligned_stack_allocator #(
	parameter int MAX_ALLOCS   = asa_pkg::MAX_ALLOCS_DEF,
	parameter int HEADER_BYTES = asa_pkg::HEADER_BYTES_DEF,
	parameter int ADDR_BITS    = asa_pkg::ADDR_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	asa_cfg_if.sink   cfg,
	asa_req_if.sink   req,
	asa_rsp_if.source rsp
);

	asa_pkg::dp_cmd_t    dp_cmd;
	asa_pkg::dp_status_t dp_status;

	// sequencing: idle -> execute -> idle
	asa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.dp_status(dp_status),
		.dp_cmd   (dp_cmd)
	);

	// address arithmetic, state registers, adjustment stack, response register
	asa_datapath #(
		.MAX_ALLOCS  (MAX_ALLOCS),
		.HEADER_BYTES(HEADER_BYTES),
		.ADDR_BITS   (ADDR_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.dp_status   (dp_status),
		.req_type    (req.req_type),
		.alloc_size  (req.alloc_size),
		.align_bytes (req.align_bytes),
		.release_addr(req.release_addr),
		.cfg         (cfg),
		.rsp         (rsp)
	);

endmodule
